// ----- hdl/double_ended_queue_with_swap_core_defines.svh -----
// Assertion helpers used by the deque core.
`ifndef DOUBLE_ENDED_QUEUE_WITH_SWAP_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SWAP_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DEQS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("deque check failed");

// Next-cycle implication, checked out of reset.
`define DEQS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

// ----- hdl/deqs_pkg.sv -----
package deqs_pkg;

	localparam int DEPTH      = 16;
	localparam int WORD_W     = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int MODE_W     = 3;
	localparam int STATUS_W   = 2;

	localparam logic [MODE_W-1:0] MODE_PUSH_TAIL = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_HEAD = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_HEAD  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PEEK_HEAD = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ_IDX  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_SWAP      = 3'd5;
	localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd6;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_TAKE_LEFT,
		CELL_TAKE_RIGHT
	} cell_op_t;

	typedef logic [WORD_W-1:0] word_t;

endpackage

// ----- hdl/deqs_if.sv -----
interface deqs_req_if;
	logic                              valid;
	logic                              ready;
	logic [deqs_pkg::MODE_W-1:0]       mode;
	logic [deqs_pkg::WORD_W-1:0]       data_in;
	logic [deqs_pkg::IDX_W-1:0]        position;

	modport source(output valid, mode, data_in, position, input ready);
	modport sink(input valid, mode, data_in, position, output ready);
endinterface

interface deqs_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [deqs_pkg::WORD_W-1:0]       data_out;
	logic [deqs_pkg::STATUS_W-1:0]     status;
	logic [deqs_pkg::CNT_W-1:0]        occupancy;
	logic                              is_empty;

	modport source(output valid, data_out, status, occupancy, is_empty, input ready);
	modport sink(input valid, data_out, status, occupancy, is_empty, output ready);
endinterface

// ----- hdl/double_ended_queue_with_swap_core.sv -----
// Bounded deque of up to DEPTH words kept as a row of cells in logical order, cell 0 being
// the head. On a request, push at head and pop shift the whole row by one
// cell, push at tail loads the cell at the count, swap exchanges two neighbor cells, and
// reads select one cell. One response per request appears from an output register the
// cycle after the transfer; a new request is taken each cycle while the response register
// is free or being drained, so the sustained rate is one item per clock.
`include "double_ended_queue_with_swap_core_defines.svh"

module double_ended_queue_with_swap_core (
	input  logic        clk,
	input  logic        arst_n,
	deqs_req_if.sink    req,
	deqs_rsp_if.source  rsp
);

	logic [deqs_pkg::CNT_W-1:0]    cnt_q;
	logic [deqs_pkg::CNT_W-1:0]    cnt_nxt;
	logic                          rsp_valid_q;
	deqs_pkg::word_t               rsp_data_q;
	logic [deqs_pkg::STATUS_W-1:0] rsp_status_q;

	deqs_pkg::word_t               words [deqs_pkg::DEPTH];
	deqs_pkg::cell_op_t            ops   [deqs_pkg::DEPTH];

	logic                          take;
	logic                          full;
	logic                          empty;
	logic                          pos_bad;
	logic [deqs_pkg::IDX_W-1:0]    pos_m1;
	logic [deqs_pkg::IDX_W-1:0]    tail_idx;
	deqs_pkg::word_t               data_nxt;
	logic [deqs_pkg::STATUS_W-1:0] status_nxt;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign take      = req.valid && req.ready;

	assign full     = (cnt_q == deqs_pkg::CNT_FULL);
	assign empty    = (cnt_q == '0);
	assign pos_bad  = ({1'b0, req.position} >= cnt_q);
	assign pos_m1   = req.position - deqs_pkg::IDX_W'(1);
	assign tail_idx = cnt_q[deqs_pkg::IDX_W-1:0];

	always_comb begin
		cnt_nxt    = cnt_q;
		data_nxt   = '0;
		status_nxt = deqs_pkg::ST_OK;
		for (int i = 0; i < deqs_pkg::DEPTH; i++) begin
			ops[i] = deqs_pkg::CELL_HOLD;
		end
		case (req.mode)
			deqs_pkg::MODE_PUSH_TAIL: begin
				if (full) begin
					status_nxt = deqs_pkg::ST_FULL;
				end else begin
					ops[tail_idx] = deqs_pkg::CELL_LOAD;
					cnt_nxt       = cnt_q + deqs_pkg::CNT_W'(1);
				end
			end
			deqs_pkg::MODE_PUSH_HEAD: begin
				if (full) begin
					status_nxt = deqs_pkg::ST_FULL;
				end else begin
					for (int i = 0; i < deqs_pkg::DEPTH; i++) begin
						ops[i] = deqs_pkg::CELL_TAKE_LEFT;
					end
					cnt_nxt = cnt_q + deqs_pkg::CNT_W'(1);
				end
			end
			deqs_pkg::MODE_POP_HEAD, deqs_pkg::MODE_PEEK_HEAD: begin
				if (empty) begin
					status_nxt = deqs_pkg::ST_EMPTY;
				end else begin
					data_nxt = words[0];
					if (req.mode == deqs_pkg::MODE_POP_HEAD) begin
						for (int i = 0; i < deqs_pkg::DEPTH; i++) begin
							ops[i] = deqs_pkg::CELL_TAKE_RIGHT;
						end
						cnt_nxt = cnt_q - deqs_pkg::CNT_W'(1);
					end
				end
			end
			deqs_pkg::MODE_READ_IDX: begin
				if (pos_bad) begin
					status_nxt = deqs_pkg::ST_BADIDX;
				end else begin
					data_nxt = words[req.position];
				end
			end
			deqs_pkg::MODE_SWAP: begin
				if (pos_bad || req.position == '0) begin
					status_nxt = deqs_pkg::ST_BADIDX;
				end else begin
					ops[pos_m1]       = deqs_pkg::CELL_TAKE_RIGHT;
					ops[req.position] = deqs_pkg::CELL_TAKE_LEFT;
				end
			end
			deqs_pkg::MODE_CLEAR: begin
				cnt_nxt = '0;
			end
			default: begin
			end
		endcase
		// cells are only touched on a transfer
		if (!take) begin
			for (int i = 0; i < deqs_pkg::DEPTH; i++) begin
				ops[i] = deqs_pkg::CELL_HOLD;
			end
		end
	end

	for (genvar g = 0; g < deqs_pkg::DEPTH; g++) begin : g_cell
		deqs_pkg::word_t left_w;
		deqs_pkg::word_t right_w;
		if (g == 0) begin : g_first
			assign left_w = req.data_in;
		end else begin : g_mid_l
			assign left_w = words[g-1];
		end
		if (g == deqs_pkg::DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = words[g+1];
		end
		deqs_cell u_cell (
			.clk        (clk),
			.op         (ops[g]),
			.load_word  (req.data_in),
			.left_word  (left_w),
			.right_word (right_w),
			.word_q     (words[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				cnt_q <= cnt_nxt;
			end
			if (take) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_data_q   <= data_nxt;
			rsp_status_q <= status_nxt;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.data_out  = rsp_data_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.occupancy = cnt_q;
	assign rsp.is_empty  = (cnt_q == '0);

	`DEQS_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= deqs_pkg::CNT_FULL)
	`DEQS_ASSERT_NXT(a_take_gives_rsp, clk, arst_n, take, rsp_valid_q)
	`DEQS_ASSERT_NXT(a_full_push_drop, clk, arst_n,
		take && full && (req.mode == deqs_pkg::MODE_PUSH_TAIL ||
		req.mode == deqs_pkg::MODE_PUSH_HEAD),
		rsp_status_q == deqs_pkg::ST_FULL && $stable(cnt_q))
	`DEQS_ASSERT_NXT(a_pop_count, clk, arst_n,
		take && !empty && req.mode == deqs_pkg::MODE_POP_HEAD,
		cnt_q == $past(cnt_q) - deqs_pkg::CNT_W'(1))
	`DEQS_ASSERT_IMP(a_no_take_hold, clk, arst_n, !take, ops[0] == deqs_pkg::CELL_HOLD)

endmodule

// ----- hdl/deqs_cell.sv -----
module deqs_cell (
	input  logic                clk,
	input  deqs_pkg::cell_op_t  op,
	input  deqs_pkg::word_t     load_word,
	input  deqs_pkg::word_t     left_word,
	input  deqs_pkg::word_t     right_word,
	output deqs_pkg::word_t     word_q
);

	always_ff @(posedge clk) begin
		case (op)
			deqs_pkg::CELL_LOAD:       word_q <= load_word;
			deqs_pkg::CELL_TAKE_LEFT:  word_q <= left_word;
			deqs_pkg::CELL_TAKE_RIGHT: word_q <= right_word;
			default:                   word_q <= word_q;
		endcase
	end

endmodule
